// File: rtl/core/mesh_tangent_accumulator_unit_macros.svh
// assertion macros for the mesh tangent accumulator
// expects i_clk and i_rst_n in the scope of use
`ifndef MESH_TANGENT_ACCUMULATOR_UNIT_MACROS_SVH
`define MESH_TANGENT_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define MTA_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define MTA_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/core/mta_pkg.sv
// shared types, constants and status codes of the mesh tangent accumulator
// no dependencies
`timescale 1ns / 1ps

package mta_pkg;

    localparam int IDX_W          = 10;
    localparam int COORD_W        = 32;
    localparam int ACC_W          = 40;
    localparam int PROD_W         = 64;
    localparam int MAX_VERTICES_DEF = 1024;

    localparam logic signed [32:0] SAT_DELTA  = 33'sd2147483647;
    localparam logic signed [40:0] ACC_MAX    = 41'sd549755813887;
    localparam logic signed [40:0] ACC_MIN    = -41'sd549755813888;
    localparam logic signed [40:0] SNAP_LIMIT = 41'sd107374;

    localparam logic CMD_CORNER = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [2:0] ST_HELD      = 3'd0;
    localparam logic [2:0] ST_FACE      = 3'd1;
    localparam logic [2:0] ST_DEGEN_UV  = 3'd2;
    localparam logic [2:0] ST_ZERO_TAN  = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_READ_EMPTY = 3'd5;

    typedef struct packed {
        logic                      command;
        logic [IDX_W-1:0]          vtx_id;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } t_in_item;

    typedef struct packed {
        logic [2:0]                status;
        logic [IDX_W-1:0]          echo_index;
        logic signed [COORD_W-1:0] tangent_x;
        logic signed [COORD_W-1:0] tangent_y;
        logic signed [COORD_W-1:0] tangent_z;
    } t_out_item;

    typedef logic [2:0][ACC_W-1:0] t_acc_row;

endpackage

// File: rtl/core/mta_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mta_mul.sv
// shared signed multiplier with a registered product
// depends on mta_pkg
`timescale 1ns / 1ps

module mta_mul
    import mta_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [COORD_W-1:0] i_a,
    input  logic signed [COORD_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/mesh_tangent_accumulator_unit.sv
// top level of the mesh tangent accumulator: sequencer, datapath, accumulator memory
// depends on mta_pkg, mta_mul, mta_ram and mesh_tangent_accumulator_unit_macros.svh
`timescale 1ns / 1ps

// Per-vertex tangent generation. Triangle corners come in one transaction at a
// time; the first two corners of a face are held and their result is loaded
// from S_FIN once the output register is free. The third corner starts the face:
// products on the one shared 32x32 multiplier (determinant and raw tangent),
// a sign step, normalizing shifts, squares, bit-serial square root and
// bit-serial division on one shared subtractor, read-modify-write to the
// accumulator memory and a final step to load the result. A degenerate uv
// face ends after the products and a zero tangent after the normalizing check.
// A read transaction reads the accumulator entry and runs the same sign, shift,
// square, square root and division steps; it ends after the normalizing check
// when the accumulator is empty and goes straight to the result when the index
// is out of range. The input is not ready while an item is being worked on; a
// finished result waits in the output register while the next transaction is
// taken, and the following result is held back until that register drains.
// After reset the accumulator memory is cleared, one entry per cycle, before
// the first transaction.

module mesh_tangent_accumulator_unit
    import mta_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

`include "mesh_tangent_accumulator_unit_macros.svh"

    localparam int AW = $clog2(MAX_VERTICES);
    localparam logic [16:0] MAXV = 17'(MAX_VERTICES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

    // sequencer states
    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_SIGN     = 4'd3;
    localparam logic [3:0] S_NSHIFT   = 4'd4;
    localparam logic [3:0] S_SQ       = 4'd5;
    localparam logic [3:0] S_SQRT     = 4'd6;
    localparam logic [3:0] S_DIV_INIT = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_ACC_RD   = 4'd9;
    localparam logic [3:0] S_ACC_WR   = 4'd10;
    localparam logic [3:0] S_RD_REQ   = 4'd11;
    localparam logic [3:0] S_RD_DATA  = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;

    // saturating delta of two Q16.16 values
    function automatic logic signed [COORD_W-1:0] sat_delta(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
        if (d > SAT_DELTA) begin
            d = SAT_DELTA;
        end else if (d < -SAT_DELTA) begin
            d = -SAT_DELTA;
        end
        return d[COORD_W-1:0];
    endfunction

    // saturating accumulate followed by the small-value snap
    function automatic logic [ACC_W-1:0] acc_add(
        input logic signed [ACC_W-1:0]   acc,
        input logic signed [COORD_W-1:0] t
    );
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(acc) + (ACC_W+1)'(t);
        if (s > ACC_MAX) begin
            s = ACC_MAX;
        end else if (s < ACC_MIN) begin
            s = ACC_MIN;
        end
        if (s <= SNAP_LIMIT && s >= -SNAP_LIMIT) begin
            s = '0;
        end
        return s[ACC_W-1:0];
    endfunction

    // control state
    logic [3:0]    r_state;
    logic [1:0]    r_cnt;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;
    logic [4:0]    r_step;
    logic [1:0]    r_comp;

    // payload state
    t_out_item                 r_out;
    t_out_item                 r_res;
    logic                      r_is_read;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          r_hidx [2];
    logic signed [COORD_W-1:0] r_hpos [2][3];
    logic signed [COORD_W-1:0] r_huv  [2][2];
    logic signed [COORD_W-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [COORD_W-1:0] r_dp1 [3];
    logic signed [COORD_W-1:0] r_dp2 [3];
    logic signed [PROD_W-1:0]  r_tmp;
    logic signed [PROD_W-1:0]  r_det;
    logic signed [PROD_W-1:0]  r_v [3];
    logic [PROD_W-1:0]         r_m [3];
    logic [2:0]                r_neg;
    logic [PROD_W-1:0]         r_sq;
    logic [PROD_W-1:0]         r_sx;
    logic [PROD_W-1:0]         r_sres;
    logic [PROD_W-1:0]         r_sbit;
    logic [31:0]               r_rem;
    logic [30:0]               r_num;
    logic [30:0]               r_q;
    logic signed [COORD_W-1:0] r_t [3];

    // shared multiplier
    logic signed [COORD_W-1:0] w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;

    // shared compare-subtract unit
    logic [PROD_W-1:0] w_sub_a, w_sub_b, w_sub_d;
    logic              w_sub_ge;

    // memory ports
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_acc_row      w_wdata, w_rdata;

    logic             w_accept;
    logic             w_slot_free;
    logic [PROD_W-1:0] w_mx;
    logic [IDX_W-1:0] w_vs;
    logic             w_vs_in;
    logic [30:0]      w_q_next;
    logic [61:0]      w_num_full;
    logic signed [COORD_W-1:0] w_t_final;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // operand selection for the multiplier
    always_comb begin
        w_mul_a = r_du1;
        w_mul_b = r_dv2;
        if (r_state == S_SQ) begin
            case (r_step[1:0])
                2'd0:    w_mul_a = {1'b0, r_m[0][30:0]};
                2'd1:    w_mul_a = {1'b0, r_m[1][30:0]};
                default: w_mul_a = {1'b0, r_m[2][30:0]};
            endcase
            w_mul_b = w_mul_a;
        end else begin
            case (r_step[2:0])
                3'd0:    begin w_mul_a = r_du1;    w_mul_b = r_dv2; end
                3'd1:    begin w_mul_a = r_dv1;    w_mul_b = r_du2; end
                3'd2:    begin w_mul_a = r_dp1[0]; w_mul_b = r_dv2; end
                3'd3:    begin w_mul_a = r_dp2[0]; w_mul_b = r_dv1; end
                3'd4:    begin w_mul_a = r_dp1[1]; w_mul_b = r_dv2; end
                3'd5:    begin w_mul_a = r_dp2[1]; w_mul_b = r_dv1; end
                3'd6:    begin w_mul_a = r_dp1[2]; w_mul_b = r_dv2; end
                default: begin w_mul_a = r_dp2[2]; w_mul_b = r_dv1; end
            endcase
        end
    end

    mta_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // subtractor serves the square root and the division steps
    always_comb begin
        if (r_state == S_SQRT) begin
            w_sub_a = r_sx;
            w_sub_b = r_sres + r_sbit;
        end else begin
            w_sub_a = PROD_W'({r_rem, r_num[30]});
            w_sub_b = PROD_W'(r_sres[31:0]);
        end
        w_sub_d  = w_sub_a - w_sub_b;
        w_sub_ge = (w_sub_a >= w_sub_b);
    end

    assign w_q_next  = {r_q[29:0], w_sub_ge};
    assign w_t_final = r_neg[r_comp] ? -COORD_W'({1'b0, w_q_next})
                                     : COORD_W'({1'b0, w_q_next});
    // numerator of the rounded division: m * 2^30 + len / 2
    assign w_num_full = {1'b0, r_m[r_comp][30:0], 30'd0} + {31'd0, r_sres[31:1]};

    // largest magnitude for the normalizing shift
    always_comb begin
        w_mx = r_m[0];
        if (r_m[1] > w_mx) begin
            w_mx = r_m[1];
        end
        if (r_m[2] > w_mx) begin
            w_mx = r_m[2];
        end
    end

    // corner vertex for the accumulate pass
    always_comb begin
        case (r_comp)
            2'd0:    w_vs = r_hidx[0];
            2'd1:    w_vs = r_hidx[1];
            default: w_vs = r_idx;
        endcase
        w_vs_in = ({7'd0, w_vs} < MAXV);
    end

    // memory access
    always_comb begin
        w_we    = 1'b0;
        w_waddr = AW'(w_vs);
        w_wdata = w_rdata;
        w_raddr = AW'(w_vs);
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == S_ACC_WR) begin
            w_we = w_vs_in;
            for (int k = 0; k < 3; k++) begin
                w_wdata[k] = acc_add(w_rdata[k], r_t[k]);
            end
        end
        if (r_state == S_RD_REQ) begin
            w_raddr = AW'(r_idx);
        end
    end

    mta_ram #(
        .WIDTH (3 * ACC_W),
        .DEPTH (MAX_VERTICES)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_comp      <= '0;
        end else begin
            // output register loads from the sequencer and drains on its own
            if (r_state == S_FIN && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (w_accept) begin
                        r_idx                <= i_in_data.vtx_id;
                        r_is_read            <= i_in_data.command;
                        r_res.echo_index     <= i_in_data.vtx_id;
                        r_res.tangent_x      <= '0;
                        r_res.tangent_y      <= '0;
                        r_res.tangent_z      <= '0;
                        if (i_in_data.command == CMD_READ) begin
                            r_res.status <= ST_READ_EMPTY;
                            if ({7'd0, i_in_data.vtx_id} < MAXV) begin
                                r_state <= S_RD_REQ;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end else if (r_cnt != 2'd2) begin
                            // first or second corner: hold it
                            r_hidx[r_cnt[0]]    <= i_in_data.vtx_id;
                            r_hpos[r_cnt[0]][0] <= i_in_data.pos_x;
                            r_hpos[r_cnt[0]][1] <= i_in_data.pos_y;
                            r_hpos[r_cnt[0]][2] <= i_in_data.pos_z;
                            r_huv[r_cnt[0]][0]  <= i_in_data.tex_u;
                            r_huv[r_cnt[0]][1]  <= i_in_data.tex_v;
                            r_cnt               <= r_cnt + 2'd1;
                            r_res.status        <= ST_HELD;
                            r_state             <= S_FIN;
                        end else begin
                            // third corner: edge and uv deltas
                            r_cnt    <= '0;
                            r_du1    <= sat_delta(r_huv[1][0], r_huv[0][0]);
                            r_dv1    <= sat_delta(r_huv[1][1], r_huv[0][1]);
                            r_du2    <= sat_delta(i_in_data.tex_u, r_huv[0][0]);
                            r_dv2    <= sat_delta(i_in_data.tex_v, r_huv[0][1]);
                            r_dp1[0] <= sat_delta(r_hpos[1][0], r_hpos[0][0]);
                            r_dp1[1] <= sat_delta(r_hpos[1][1], r_hpos[0][1]);
                            r_dp1[2] <= sat_delta(r_hpos[1][2], r_hpos[0][2]);
                            r_dp2[0] <= sat_delta(i_in_data.pos_x, r_hpos[0][0]);
                            r_dp2[1] <= sat_delta(i_in_data.pos_y, r_hpos[0][1]);
                            r_dp2[2] <= sat_delta(i_in_data.pos_z, r_hpos[0][2]);
                            r_step   <= '0;
                            r_state  <= S_MUL;
                        end
                    end
                end

                S_MUL: begin
                    // product of the pair issued last cycle is on w_prod
                    r_step <= r_step + 5'd1;
                    if (r_step != 5'd0) begin
                        if (r_step[0]) begin
                            r_tmp <= w_prod;
                        end else begin
                            case (r_step[3:1])
                                3'd1:    r_det  <= r_tmp - w_prod;
                                3'd2:    r_v[0] <= r_tmp - w_prod;
                                3'd3:    r_v[1] <= r_tmp - w_prod;
                                default: r_v[2] <= r_tmp - w_prod;
                            endcase
                        end
                    end
                    if (r_step == 5'd8) begin
                        if (r_det == '0) begin
                            r_res.status <= ST_DEGEN_UV;
                            r_state      <= S_FIN;
                        end else begin
                            r_state <= S_SIGN;
                        end
                    end
                end

                S_SIGN: begin
                    // flip by the determinant sign for faces only
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= r_v[k][PROD_W-1] ^ (!r_is_read && r_det[PROD_W-1]);
                        r_m[k]   <= r_v[k][PROD_W-1] ? PROD_W'(-r_v[k]) : PROD_W'(r_v[k]);
                    end
                    r_state <= S_NSHIFT;
                end

                S_NSHIFT: begin
                    // bring the largest magnitude into [2^30, 2^31)
                    if (w_mx == '0) begin
                        r_res.status <= r_is_read ? ST_READ_EMPTY : ST_ZERO_TAN;
                        r_state      <= S_FIN;
                    end else if (w_mx[62:39] != '0) begin
                        for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] >> 8;
                    end else if (w_mx[38:31] != '0) begin
                        for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] >> 1;
                    end else if (w_mx[30:22] == '0) begin
                        for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] << 8;
                    end else if (!w_mx[30]) begin
                        for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] << 1;
                    end else begin
                        r_sq    <= '0;
                        r_step  <= '0;
                        r_state <= S_SQ;
                    end
                end

                S_SQ: begin
                    if (r_step != 5'd0) begin
                        r_sq <= r_sq + $unsigned(w_prod);
                    end
                    if (r_step == 5'd3) begin
                        r_sx    <= r_sq + $unsigned(w_prod);
                        r_sres  <= '0;
                        r_sbit  <= PROD_W'(1) << 62;
                        r_step  <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                end

                S_SQRT: begin
                    // one result bit per cycle
                    if (w_sub_ge) begin
                        r_sx   <= w_sub_d;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) begin
                        r_comp  <= '0;
                        r_state <= S_DIV_INIT;
                    end
                end

                S_DIV_INIT: begin
                    // quotient fits 31 bits, so the top part starts as remainder
                    r_rem   <= {1'b0, w_num_full[61:31]};
                    r_num   <= w_num_full[30:0];
                    r_q     <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_rem  <= w_sub_ge ? w_sub_d[31:0] : w_sub_a[31:0];
                    r_num  <= {r_num[29:0], 1'b0};
                    r_q    <= w_q_next;
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd30) begin
                        r_t[r_comp] <= w_t_final;
                        if (r_comp == 2'd2) begin
                            r_res.tangent_x <= r_t[0];
                            r_res.tangent_y <= r_t[1];
                            r_res.tangent_z <= w_t_final;
                            r_comp          <= '0;
                            if (r_is_read) begin
                                r_res.status <= ST_READ_OK;
                                r_state      <= S_FIN;
                            end else begin
                                r_state <= S_ACC_RD;
                            end
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_DIV_INIT;
                        end
                    end
                end

                S_ACC_RD: begin
                    r_state <= S_ACC_WR;
                end

                S_ACC_WR: begin
                    // write happens this cycle when the corner is in range
                    if (r_comp == 2'd2) begin
                        r_res.status <= ST_FACE;
                        r_state      <= S_FIN;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_ACC_RD;
                    end
                end

                S_RD_REQ: begin
                    r_state <= S_RD_DATA;
                end

                S_RD_DATA: begin
                    for (int k = 0; k < 3; k++) begin
                        r_v[k] <= PROD_W'($signed(w_rdata[k]));
                    end
                    r_state <= S_SIGN;
                end

                S_FIN: begin
                    if (w_slot_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MTA_ASSERT_NXT(a_accept_drops_ready, w_accept, !o_in_ready, "ready held after accept")
    `MTA_ASSERT_IMP(a_clear_no_output, r_state == S_CLR, !o_out_valid, "result during clear")
    `MTA_ASSERT_IMP(a_sqrt_range, r_state == S_DIV_INIT, r_sres[31:30] != 2'b00, "length out of range")
    `MTA_ASSERT_IMP(a_face_nonzero, o_out_valid && o_out_data.status == ST_FACE, (o_out_data.tangent_x != '0) || (o_out_data.tangent_y != '0) || (o_out_data.tangent_z != '0), "zero face tangent")

endmodule
